// ===== src/pmc_pkg.sv =====
package pmc_pkg;

  localparam int unsigned DATA_W   = 16;
  localparam int unsigned REF_W    = 8;
  localparam int unsigned DUTY_W   = 15;
  localparam int unsigned ERR_W    = 17;
  localparam int unsigned SUM_W    = 18;
  localparam int unsigned KPP_W    = 34;
  localparam int unsigned TOT_W    = 42;
  localparam int unsigned MAG_W    = 26;
  localparam int unsigned MUL_A_W  = 25;
  localparam int unsigned MUL_B_W  = 26;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  localparam int unsigned DUTY_MAX = 20000;
  localparam logic [MAG_W-1:0] DUTY_MAX_MAG = MAG_W'(DUTY_MAX);

  // ceil(2^32 / 255): exact floor(x / 255) for any 24-bit x as (x * RECIP_255) >> 32
  localparam logic [MUL_B_W-2:0] RECIP_255 = 25'd16843010;

  localparam logic [DATA_W-1:0] KP_RST   = 16'd256;
  localparam logic [DATA_W-1:0] DT_RST   = 16'd655;
  localparam logic [DATA_W-1:0] LIM_RST  = 16'd50000;
  localparam logic [DATA_W-1:0] SPAN_RST = 16'd5600;

  typedef enum logic [1:0] {
    REG_KP   = 2'd0,
    REG_DT   = 2'd1,
    REG_LIM  = 2'd2,
    REG_SPAN = 2'd3
  } pmc_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RECIP,
    ST_ERR,
    ST_PROP,
    ST_INTEG,
    ST_SUM,
    ST_OUT
  } pmc_state_e;

  typedef struct packed {
    logic [DATA_W-1:0] kp_gain;
    logic [DATA_W-1:0] dt_gain;
    logic [DATA_W-1:0] integral_limit;
    logic [DATA_W-1:0] position_span;
  } pmc_cfg_t;

endpackage

// ===== src/pi_position_motor_controller.sv =====
// Channel   | Direction | Signals                                 | Contents (low bit up)
// s_axis    | in        | s_axis_tvalid/tready/tdata[23:0]        | reference_byte, encoder_position
// m_axis    | out       | m_axis_tvalid/tready/tdata[15:0]        | drive_direction, drive_duty
// apb       | cfg       | psel/penable/pwrite/paddr[3:0]/pwdata   | 0x0 kp, 0x4 dt, 0x8 limit, 0xC span
//
// Each result comes from seven sequencer steps around a single shared 25x26 multiplier,
// which follow the idle step that takes the transfer.
// s_axis_tready is high only while the sequencer is idle; a finished result sits in the
// output register, so the next tick is taken while it waits on m_axis_tready.
// A stalled output holds the sequencer in its last step until the register frees.
// Reset clears the error integral and loads the register defaults; no clearing pass.
module pi_position_motor_controller
  import pmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // [7:0] reference_byte, [23:8] encoder_position
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [0] drive_direction, [15:1] drive_duty
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  pmc_cfg_t          cfg;
  logic              dir;
  logic [DUTY_W-1:0] duty;

  pmc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pmc_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (s_axis_tvalid),
    .in_ready_o         (s_axis_tready),
    .reference_byte_i   (s_axis_tdata[7:0]),
    .encoder_position_i (s_axis_tdata[23:8]),
    .out_valid_o        (m_axis_tvalid),
    .out_ready_i        (m_axis_tready),
    .drive_direction_o  (dir),
    .drive_duty_o       (duty)
  );

  assign m_axis_tdata = {duty, dir};

endmodule

// ===== src/pmc_cfg_regs.sv =====
module pmc_cfg_regs
  import pmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output pmc_cfg_t          cfg_o
);

  pmc_cfg_t cfg_q, cfg_d;
  pmc_reg_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = pmc_reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_KP:   cfg_d.kp_gain        = pwdata[DATA_W-1:0];
        REG_DT:   cfg_d.dt_gain        = pwdata[DATA_W-1:0];
        REG_LIM:  cfg_d.integral_limit = pwdata[DATA_W-1:0];
        REG_SPAN: cfg_d.position_span  = pwdata[DATA_W-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KP:   prdata = {16'b0, cfg_q.kp_gain};
      REG_DT:   prdata = {16'b0, cfg_q.dt_gain};
      REG_LIM:  prdata = {16'b0, cfg_q.integral_limit};
      REG_SPAN: prdata = {16'b0, cfg_q.position_span};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain        <= KP_RST;
      cfg_q.dt_gain        <= DT_RST;
      cfg_q.integral_limit <= LIM_RST;
      cfg_q.position_span  <= SPAN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/pmc_mul.sv =====
module pmc_mul
  import pmc_pkg::*;
(
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== src/pmc_core.sv =====
module pmc_core
  import pmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pmc_cfg_t          cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [REF_W-1:0]  reference_byte_i,
  input  logic [DATA_W-1:0] encoder_position_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              drive_direction_o,
  output logic [DUTY_W-1:0] drive_duty_o
);

  pmc_state_e state_q, state_d;

  logic        [REF_W-1:0]  ref_q;
  logic        [DATA_W-1:0] enc_q;
  logic signed [ERR_W-1:0]  error_q, error_d;
  logic signed [SUM_W-1:0]  error_sum_q, error_sum_d;
  logic signed [KPP_W-1:0]  kp_prod_q;
  logic signed [TOT_W-1:0]  total_q, total_d;

  logic                     out_valid_q, out_valid_d;
  logic                     dir_q, dir_d;
  logic        [DUTY_W-1:0] duty_q, duty_d;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic signed [SUM_W-1:0]  lim_s, sum_raw;
  logic        [TOT_W-1:0]  mag_full;
  logic        [MAG_W-1:0]  mag;
  logic        [MAG_W-1:0]  mag_sat;
  logic                     out_load;

  pmc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign lim_s   = $signed({2'b0, cfg_i.integral_limit});
  assign sum_raw = error_sum_q + SUM_W'(error_q);

  // Q.16 total -> magnitude truncated toward zero
  assign mag_full = total_q[TOT_W-1] ? TOT_W'(-total_q) : TOT_W'(total_q);
  assign mag      = mag_full[TOT_W-1:16];
  assign mag_sat  = (mag > DUTY_MAX_MAG) ? DUTY_MAX_MAG : mag;

  always_comb begin
    state_d     = state_q;
    error_d     = error_q;
    error_sum_d = error_sum_q;
    total_d     = total_q;
    mul_a       = '0;
    mul_b       = '0;
    out_load    = 1'b0;
    dir_d       = dir_q;
    duty_d      = duty_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        mul_a   = $signed({17'b0, ref_q});
        mul_b   = $signed({10'b0, cfg_i.position_span});
        state_d = ST_RECIP;
      end
      ST_RECIP: begin
        mul_a   = $signed({1'b0, mul_p[23:0]});
        mul_b   = $signed({1'b0, RECIP_255});
        state_d = ST_ERR;
      end
      ST_ERR: begin
        error_d = $signed({1'b0, mul_p[47:32]}) - $signed({1'b0, enc_q});
        state_d = ST_PROP;
      end
      ST_PROP: begin
        mul_a = $signed({{(MUL_A_W-ERR_W){error_q[ERR_W-1]}}, error_q});
        mul_b = $signed({10'b0, cfg_i.kp_gain});
        if (sum_raw > lim_s) begin
          error_sum_d = lim_s;
        end else if (sum_raw < -lim_s) begin
          error_sum_d = -lim_s;
        end else begin
          error_sum_d = sum_raw;
        end
        state_d = ST_INTEG;
      end
      ST_INTEG: begin
        mul_a   = $signed({{(MUL_A_W-SUM_W){error_sum_q[SUM_W-1]}}, error_sum_q});
        mul_b   = $signed({10'b0, cfg_i.dt_gain});
        state_d = ST_SUM;
      end
      ST_SUM: begin
        total_d = $signed({kp_prod_q, 8'b0}) + $signed(mul_p[TOT_W-1:0]);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          dir_d       = total_q[TOT_W-1] && (mag != '0);
          duty_d      = mag_sat[DUTY_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      error_sum_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      error_sum_q <= error_sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      ref_q <= reference_byte_i;
      enc_q <= encoder_position_i;
    end
    if (state_q == ST_INTEG) kp_prod_q <= mul_p[KPP_W-1:0];
    error_q <= error_d;
    total_q <= total_d;
    dir_q   <= dir_d;
    duty_q  <= duty_d;
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign drive_direction_o = dir_q;
  assign drive_duty_o      = duty_q;

`ifndef ASSERT_OFF
  a_sum_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INTEG) |-> (error_sum_q <= lim_s) && (error_sum_q >= -lim_s))
    else $error("error_sum outside integral limit");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output step");

  a_duty_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (MAG_W'(duty_q) <= DUTY_MAX_MAG))
    else $error("duty above saturation limit");

  // held result: a negative drive always has a nonzero duty
  a_dir_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && dir_q) |-> (duty_q != '0))
    else $error("negative direction with zero drive");

  a_load_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");
`endif

endmodule
